@@ design/tpc_pkg.sv @@
`timescale 1ns / 1ps

package tpc_pkg;

  localparam int unsigned AXES = 3;

  typedef struct packed {
    logic signed [31:0] error_x;
    logic signed [31:0] error_y;
    logic signed [31:0] error_z;
    logic        [15:0] delta_t;
  } tpc_in_t;

  typedef struct packed {
    logic signed [31:0] drive_x;
    logic signed [31:0] drive_y;
    logic signed [31:0] drive_z;
    logic        [2:0]  clamp_mask;
  } tpc_out_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN_X   = 3'd0,
    REG_PROP_GAIN_Y   = 3'd1,
    REG_PROP_GAIN_Z   = 3'd2,
    REG_INT_GAIN_X    = 3'd3,
    REG_INT_GAIN_Y    = 3'd4,
    REG_INT_GAIN_Z    = 3'd5,
    REG_ERROR_MAX     = 3'd6,
    REG_INTEGRAL_MAX  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic s2_en;
    logic s3_en;
  } tpc_ctrl_t;

  function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                   input logic [30:0] lim);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed({33'd0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

@@ design/tpc_chan_if.sv @@
`timescale 1ns / 1ps

interface tpc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/tpc_lane.sv @@
`timescale 1ns / 1ps

module tpc_lane #(
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpc_pkg::tpc_ctrl_t  ctrl_i,
  input  logic signed [31:0]  error_i,
  input  logic        [15:0]  delta_t_i,
  input  logic signed [15:0]  prop_gain_i,
  input  logic signed [15:0]  int_gain_i,
  input  logic        [30:0]  error_max_i,
  input  logic        [30:0]  integral_max_i,
  output logic signed [47:0]  p_o,
  output logic signed [31:0]  integ_o
);

  logic signed [31:0] e_d, e_q;
  logic signed [32:0] kidt_d, kidt_q;
  logic signed [64:0] prod_i_d, prod_i_q;
  logic signed [47:0] prod_p_d, prod_p_q;
  logic signed [63:0] inc;
  logic signed [63:0] sum;
  logic signed [31:0] integ_d, integ_q;
  logic signed [47:0] p_d, p_q;

  // stage 1: error clamp, integral gain times ticks
  assign e_d    = 32'(tpc_pkg::clamp_sym(64'(error_i), error_max_i));
  assign kidt_d = 33'(int_gain_i) * $signed({17'd0, delta_t_i});

  // stage 2: the two products
  assign prod_i_d = 65'(e_q) * 65'(kidt_q);
  assign prod_p_d = 48'(e_q) * 48'(prop_gain_i);

  // stage 3: floor shift, integrator update
  assign inc     = 64'(prod_i_q >>> GAIN_FRAC_BITS);
  assign sum     = 64'(integ_q) + inc;
  assign integ_d = 32'(tpc_pkg::clamp_sym(sum, integral_max_i));
  assign p_d     = prod_p_q >>> GAIN_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      e_q    <= e_d;
      kidt_q <= kidt_d;
    end
    if (ctrl_i.s2_en) begin
      prod_i_q <= prod_i_d;
      prod_p_q <= prod_p_d;
    end
    if (ctrl_i.s3_en) begin
      p_q <= p_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctrl_i.s3_en) begin
      integ_q <= integ_d;
    end
  end

  assign p_o     = p_q;
  assign integ_o = integ_q;

endmodule

@@ design/tpc_merge.sv @@
`timescale 1ns / 1ps

module tpc_merge #(
  parameter int unsigned OUTPUT_LIMIT = 6553600
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               v3_i,
  input  logic signed [47:0] p_i     [tpc_pkg::AXES],
  input  logic signed [31:0] integ_i [tpc_pkg::AXES],
  output logic               take_o,
  tpc_chan_if.source         out_if
);

  localparam logic [30:0] Lim = 31'(OUTPUT_LIMIT);

  logic signed [63:0] sum     [tpc_pkg::AXES];
  logic signed [31:0] drive   [tpc_pkg::AXES];
  logic        [2:0]  hit;
  logic               out_valid_d, out_valid_q;
  tpc_pkg::tpc_out_t  out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i]   = 64'(p_i[i]) + 64'(integ_i[i]);
      drive[i] = 32'(tpc_pkg::clamp_sym(sum[i], Lim));
      hit[i]   = (sum[i] > $signed({33'd0, Lim})) || (sum[i] < -$signed({33'd0, Lim}));
    end
  end

  assign take_o = v3_i && (!out_valid_q || out_if.ready);

  always_comb begin
    out_d.drive_x    = drive[0];
    out_d.drive_y    = drive[1];
    out_d.drive_z    = drive[2];
    out_d.clamp_mask = hit;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

endmodule

@@ design/three_axis_pi_controller.sv @@
`timescale 1ns / 1ps
// an input beat passes through the three lane stages and the output register
// before its result is offered; with one vector in flight, a new input beat
// is accepted only after the last one leaves the lanes for the output register
// reset: gains and integrators clear to zero, both clamp limits go to 2^31-1,
// no result is pending

module three_axis_pi_controller #(
  parameter int unsigned OUTPUT_LIMIT   = 6553600,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  tpc_chan_if.sink    in_if,
  tpc_chan_if.source  out_if
);

  logic signed [15:0] kp_q [tpc_pkg::AXES];
  logic signed [15:0] ki_q [tpc_pkg::AXES];
  logic        [30:0] emax_q, imax_q;
  logic               v1_q, v2_q, v3_q;
  logic               v1_d, v2_d, v3_d;
  logic               take;
  logic               accept;
  tpc_pkg::tpc_ctrl_t ctrl;
  logic signed [31:0] err   [tpc_pkg::AXES];
  logic signed [47:0] p     [tpc_pkg::AXES];
  logic signed [31:0] integ [tpc_pkg::AXES];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        kp_q[i] <= '0;
        ki_q[i] <= '0;
      end
      emax_q <= '1;
      imax_q <= '1;
    end else if (cfg_we_i) begin
      unique case (tpc_pkg::reg_idx_e'(cfg_idx_i))
        tpc_pkg::REG_PROP_GAIN_X:  kp_q[0] <= cfg_data_i[15:0];
        tpc_pkg::REG_PROP_GAIN_Y:  kp_q[1] <= cfg_data_i[15:0];
        tpc_pkg::REG_PROP_GAIN_Z:  kp_q[2] <= cfg_data_i[15:0];
        tpc_pkg::REG_INT_GAIN_X:   ki_q[0] <= cfg_data_i[15:0];
        tpc_pkg::REG_INT_GAIN_Y:   ki_q[1] <= cfg_data_i[15:0];
        tpc_pkg::REG_INT_GAIN_Z:   ki_q[2] <= cfg_data_i[15:0];
        tpc_pkg::REG_ERROR_MAX:    emax_q  <= cfg_data_i;
        tpc_pkg::REG_INTEGRAL_MAX: imax_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one vector in flight through the lanes
  assign in_if.ready = !(v1_q || v2_q || v3_q);
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    v1_d = accept;
    v2_d = v1_q;
    v3_d = v2_q || (v3_q && !take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign ctrl.load  = accept;
  assign ctrl.s2_en = v1_q;
  assign ctrl.s3_en = v2_q;

  assign err[0] = in_if.data.error_x;
  assign err[1] = in_if.data.error_y;
  assign err[2] = in_if.data.error_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tpc_lane #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .error_i        (err[g]),
      .delta_t_i      (in_if.data.delta_t),
      .prop_gain_i    (kp_q[g]),
      .int_gain_i     (ki_q[g]),
      .error_max_i    (emax_q),
      .integral_max_i (imax_q),
      .p_o            (p[g]),
      .integ_o        (integ[g])
    );
  end

  tpc_merge #(
    .OUTPUT_LIMIT(OUTPUT_LIMIT)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .v3_i    (v3_q),
    .p_i     (p),
    .integ_i (integ),
    .take_o  (take),
    .out_if  (out_if)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({v1_q, v2_q, v3_q}))
    else $error("more than one vector in the lanes");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> v2_q)
    else $error("stage two lost a vector");

  a_result_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_if.valid && !v3_q)
    else $error("result register not loaded after take");

  a_mask_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.clamp_mask[0]) |->
    (out_if.data.drive_x == $signed(32'(OUTPUT_LIMIT)) ||
     out_if.data.drive_x == -$signed(32'(OUTPUT_LIMIT))))
    else $error("x clamp flagged without a limited drive");

endmodule

@@ tb/three_axis_pi_controller_tb.sv @@
`timescale 1ns / 1ps

module three_axis_pi_controller_tb;

  localparam longint DRIVE_LIM  = 6553600;
  localparam int     FRAC_BITS  = 12;
  localparam int     HOLD_LEN   = 400;
  localparam int     CYCLE_CAP  = 500000;
  localparam int     RAND_ITEMS = 275;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [2:0]  cfg_idx_i  = '0;
  logic [30:0] cfg_data_i = '0;

  tpc_chan_if #(.payload_t(tpc_pkg::tpc_in_t))  vec_ch ();
  tpc_chan_if #(.payload_t(tpc_pkg::tpc_out_t)) drv_ch ();

  logic             feed_valid = 1'b0;
  tpc_pkg::tpc_in_t feed_data  = '0;
  logic             take_ready = 1'b0;

  assign vec_ch.valid = feed_valid;
  assign vec_ch.data  = feed_data;
  assign drv_ch.ready = take_ready;

  three_axis_pi_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (vec_ch),
    .out_if     (drv_ch)
  );

  // controller state as the testbench sees it
  longint kp [3]    = '{0, 0, 0};
  longint ki [3]    = '{0, 0, 0};
  longint integ [3] = '{0, 0, 0};
  longint err_lim   = 64'd2147483647;
  longint int_lim   = 64'd2147483647;

  tpc_pkg::tpc_in_t  vector_q [$];
  tpc_pkg::tpc_out_t drive_q [$];
  tpc_pkg::tpc_out_t want_drive;

  int fail_count    = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int clamped_count = 0;
  int cycle_count   = 0;
  int setting_count = 1;

  int   burst_left = 0;
  int   gap_left   = 0;
  int   stall_pct  = 0;
  int   epoch_left = 0;
  int   hold_left  = 0;
  logic hold_req   = 1'b0;
  logic hold_done  = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint limit_sym(longint val, longint lim);
    if (val > lim) begin
      return lim;
    end else if (val < -lim) begin
      return -lim;
    end
    return val;
  endfunction

  function automatic tpc_pkg::tpc_out_t predict_drive(tpc_pkg::tpc_in_t v);
    logic signed [31:0] ev [3];
    logic signed [31:0] dv [3];
    logic [2:0]         mask;
    longint             e, inc, acc, p, sum, dt;
    tpc_pkg::tpc_out_t  r;
    ev[0] = v.error_x;
    ev[1] = v.error_y;
    ev[2] = v.error_z;
    dt    = longint'(v.delta_t);
    mask  = '0;
    for (int a = 0; a < 3; a++) begin
      e        = limit_sym(longint'(ev[a]), err_lim);
      inc      = (e * ki[a] * dt) >>> FRAC_BITS;
      acc      = limit_sym(integ[a] + inc, int_lim);
      integ[a] = acc;
      p        = (e * kp[a]) >>> FRAC_BITS;
      sum      = p + acc;
      if (sum > DRIVE_LIM || sum < -DRIVE_LIM) begin
        mask[a] = 1'b1;
      end
      dv[a] = 32'(limit_sym(sum, DRIVE_LIM));
    end
    r.drive_x    = dv[0];
    r.drive_y    = dv[1];
    r.drive_z    = dv[2];
    r.clamp_mask = mask;
    return r;
  endfunction

  function automatic int rand_span(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic logic signed [31:0] pick_error();
    logic signed [31:0] lim;
    logic signed [31:0] r;
    lim = 32'(err_lim);
    case ($urandom_range(0, 7))
      0: r = $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: r = 32'sh8000_0000;
          1: r = 32'sh7FFF_FFFF;
          2: r = 0;
          3: r = lim;
          4: r = -lim;
          5: r = lim + 1;
          default: r = -lim - 1;
        endcase
      end
      default: r = rand_span(32'h0100_0000);
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  task automatic write_reg(tpc_pkg::reg_idx_e idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx) inside
      tpc_pkg::REG_PROP_GAIN_X, tpc_pkg::REG_PROP_GAIN_Y, tpc_pkg::REG_PROP_GAIN_Z: begin
        kp[int'(idx)] = longint'($signed(val[15:0]));
      end
      tpc_pkg::REG_INT_GAIN_X, tpc_pkg::REG_INT_GAIN_Y, tpc_pkg::REG_INT_GAIN_Z: begin
        ki[int'(idx) - int'(tpc_pkg::REG_INT_GAIN_X)] = longint'($signed(val[15:0]));
      end
      tpc_pkg::REG_ERROR_MAX: err_lim = longint'(val);
      tpc_pkg::REG_INTEGRAL_MAX: int_lim = longint'(val);
      default: ;
    endcase
  endtask

  // gain writes carry random junk above bit 15
  task automatic load_setting(int kpx, int kpy, int kpz, int kix, int kiy, int kiz,
                              logic [30:0] emax, logic [30:0] imax);
    write_reg(tpc_pkg::REG_PROP_GAIN_X, {15'($urandom), 16'(kpx)});
    write_reg(tpc_pkg::REG_PROP_GAIN_Y, {15'($urandom), 16'(kpy)});
    write_reg(tpc_pkg::REG_PROP_GAIN_Z, {15'($urandom), 16'(kpz)});
    write_reg(tpc_pkg::REG_INT_GAIN_X, {15'($urandom), 16'(kix)});
    write_reg(tpc_pkg::REG_INT_GAIN_Y, {15'($urandom), 16'(kiy)});
    write_reg(tpc_pkg::REG_INT_GAIN_Z, {15'($urandom), 16'(kiz)});
    write_reg(tpc_pkg::REG_ERROR_MAX, emax);
    write_reg(tpc_pkg::REG_INTEGRAL_MAX, imax);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  task automatic wait_idle();
    while (vector_q.size() != 0 || drive_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic push_vec(logic signed [31:0] ex, logic signed [31:0] ey,
                          logic signed [31:0] ez, logic [15:0] dt);
    tpc_pkg::tpc_in_t v;
    v.error_x = ex;
    v.error_y = ey;
    v.error_z = ez;
    v.delta_t = dt;
    vector_q.push_back(v);
  endtask

  // mostly runs of same-signed errors to wind and unwind the integrators
  task automatic queue_random(int count);
    logic signed [31:0] centre [3];
    logic signed [31:0] ev [3];
    int                 run_left;
    bit                 noisy;
    run_left = 0;
    noisy    = 1'b0;
    @(negedge clk_i);
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 30);
        noisy    = ($urandom_range(0, 3) == 0);
        for (int a = 0; a < 3; a++) begin
          centre[a] = rand_span(32'h0200_0000);
        end
      end
      run_left--;
      for (int a = 0; a < 3; a++) begin
        ev[a] = noisy ? pick_error() : centre[a] + rand_span(32'h0001_0000);
      end
      push_vec(ev[0], ev[1], ev[2], pick_ticks());
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_valid <= 1'b0;
      feed_data  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (feed_valid && vec_ch.ready) begin
        void'(vector_q.pop_front());
      end
      if (!feed_valid || vec_ch.ready) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          feed_valid <= 1'b0;
        end else if (vector_q.size() != 0) begin
          feed_valid <= 1'b1;
          feed_data  <= vector_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall rate changes per epoch, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
      stall_pct  <= 0;
      epoch_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (epoch_left == 0) begin
        epoch_left <= $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 25;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        epoch_left <= epoch_left - 1;
      end
      if (hold_req && !hold_done) begin
        hold_done  <= 1'b1;
        hold_left  <= HOLD_LEN;
        take_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        take_ready <= 1'b0;
      end else begin
        take_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // monitor: predict on each input beat, check on each output beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vec_ch.valid && vec_ch.ready) begin
        drive_q.push_back(predict_drive(vec_ch.data));
        sent_count++;
      end
      if (drv_ch.valid && drv_ch.ready) begin
        if (drive_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, drive_x %0d", $time, drv_ch.data.drive_x);
        end else begin
          want_drive = drive_q.pop_front();
          checked_count++;
          if (drv_ch.data.clamp_mask != 3'd0) begin
            clamped_count++;
          end
          check_field("drive_x", want_drive.drive_x, drv_ch.data.drive_x);
          check_field("drive_y", want_drive.drive_y, drv_ch.data.drive_y);
          check_field("drive_z", want_drive.drive_z, drv_ch.data.drive_z);
          check_field("clamp_mask", want_drive.clamp_mask, drv_ch.data.clamp_mask);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               drive_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero gains
    @(negedge clk_i);
    push_vec(0, 0, 0, 0);
    push_vec(32'sh7FFF_FFFF, 32'sh8000_0000, 12345, 16'hFFFF);
    push_vec(-7, 65536, 32'sh7FFF_FFFF, 16'd1);
    wait_idle();

    // directed
    load_setting(4096, -2048, 8192, 64, -128, 300, 31'(200 << 16), 31'(50 << 16));
    @(negedge clk_i);
    push_vec(0, 0, 0, 0);
    push_vec(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 16'd1);
    push_vec(200 << 16, -(200 << 16), (200 << 16) + 1, 16'd100);
    push_vec(-(200 << 16) - 1, (200 << 16) - 1, -1, 16'hFFFF);
    push_vec(1, -1, 65536, 16'd0);
    push_vec(-5, -3, -4097, 16'd1);
    for (int n = 0; n < 5; n++) begin
      push_vec(150 << 16, -(150 << 16), 100 << 16, 16'd1000);
    end
    for (int n = 0; n < 5; n++) begin
      push_vec(-(180 << 16), 180 << 16, -(120 << 16), 16'd500);
    end
    push_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
    push_vec(0, 0, 0, 0);
    wait_idle();

    // moderate gains, with the long output hold-off
    load_setting(rand_span(8192), rand_span(8192), rand_span(8192),
                 rand_span(512), rand_span(512), rand_span(512),
                 31'($urandom_range(1, 1000 << 16)), 31'($urandom_range(1, 200 << 16)));
    @(posedge clk_i);
    hold_req <= 1'b1;
    queue_random(RAND_ITEMS);
    wait_idle();

    load_setting(32767, 32767, 32767, -32768, -32768, -32768, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_random(RAND_ITEMS);
    wait_idle();

    // error limit of zero
    load_setting(-32768, -32768, -32768, 32767, 32767, 32767,
                 31'd0, 31'($urandom_range(1, 300 << 16)));
    queue_random(RAND_ITEMS);
    wait_idle();

    // integrator limit of zero
    load_setting(rand_span(32768), rand_span(32768), rand_span(32768),
                 rand_span(32768), rand_span(32768), rand_span(32768),
                 31'($urandom), 31'd0);
    queue_random(RAND_ITEMS);
    wait_idle();

    load_setting(rand_span(32768), rand_span(32768), rand_span(32768),
                 rand_span(32768), rand_span(32768), rand_span(32768),
                 31'($urandom), 31'($urandom));
    queue_random(RAND_ITEMS);
    wait_idle();

    load_setting(rand_span(2048), rand_span(2048), rand_span(2048),
                 rand_span(64), rand_span(64), rand_span(64),
                 31'($urandom_range(0, 4 << 16)), 31'($urandom_range(0, 400 << 16)));
    queue_random(RAND_ITEMS);
    wait_idle();

    repeat (10) @(negedge clk_i);
    $display("%0d error vectors over %0d register settings, %0d results checked",
             sent_count, setting_count, checked_count);
    $display("%0d results had at least one axis on the output clamp", clamped_count);
    if (fail_count == 0 && drive_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tpc_pkg.sv
design/tpc_chan_if.sv
design/tpc_lane.sv
design/tpc_merge.sv
design/three_axis_pi_controller.sv
tb/three_axis_pi_controller_tb.sv
